// ===== design/rcsbp_pkg.sv =====
// Package: types, constants and helpers for the size-class block pool.
`timescale 1ns / 1ps
package rcsbp_pkg;

  localparam int SLOTS_PER_CLASS = 256;
  localparam int NUM_CLASSES     = 3;
  localparam int TOTAL_SLOTS     = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int SLOT_W          = $clog2(SLOTS_PER_CLASS);
  localparam int GIDX_W          = $clog2(TOTAL_SLOTS);
  localparam int TOP_W           = $clog2(SLOTS_PER_CLASS + 1);
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_RETAIN  = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_QUERY   = 3'd3,
    ACT_STATS   = 3'd4,
    ACT_SWEEP   = 3'd5
  } action_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HND   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_REF_ERR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXREQ = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_ACT,
    S_MUL,
    S_SWEEP_RD,
    S_SWEEP_CHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [19:0] length;
    logic [1:0]  class_num;
    logic [11:0] slot_index;
    logic [31:0] now_ms;
    logic [31:0] age_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  hnd_class;
    logic [11:0] handle_slot;
    logic [31:0] byte_offset;
    logic [19:0] blob_length;
    logic [15:0] ref_count;
    logic [12:0] in_use;
    logic [12:0] peak_used;
    logic [31:0] failure_count;
    logic [13:0] stale_count;
    logic        all_free;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [19:0]          data;
  } cfg_item_t;

  function automatic logic [GIDX_W-1:0] gidx(input logic [1:0] c, input logic [SLOT_W-1:0] s);
    gidx = GIDX_W'(c) * GIDX_W'(SLOTS_PER_CLASS) + GIDX_W'(s);
  endfunction

endpackage

// ===== design/rcsbp_if.sv =====
// Interfaces: valid/ready channels for items, results and register writes.
`timescale 1ns / 1ps
interface rcsbp_in_if import rcsbp_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcsbp_out_if import rcsbp_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcsbp_cfg_if import rcsbp_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/refcounted_size_class_block_pool.sv =====
// Top level: sequencer, slot memories and shared multiplier of the block pool.
//
//  channel | dir | payload                     | beat when
//  in_     | in  | action,length,class,slot,.. | in_valid & in_ready
//  out_    | out | status,handle,offset,...    | out_valid & out_ready
//  cfg_    | in  | register index, data        | cfg_valid & cfg_ready
//
// Alloc, retain, release and query pass accept, read, act and multiply, then
// the output beat. A refcount error skips the multiply; a bad handle, a rejected
// alloc, stats and unused actions go from read straight to the output. The sweep
// reads and checks each of the 768 slots in turn through one memory port.
// After reset a clearing pass initialises the memories and the free stacks; no
// item is accepted then. cfg writes are taken at all times. in_ready is low from
// acceptance until the result beat leaves; the result waits in the output state
// while out_ready is low.
`timescale 1ns / 1ps
module refcounted_size_class_block_pool import rcsbp_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  rcsbp_in_if.sink    in_ch,
  rcsbp_out_if.source out_ch,
  rcsbp_cfg_if.sink   cfg_ch
);

  // memories
  logic [SLOT_W-1:0] stack_mem [TOTAL_SLOTS];
  logic [15:0]       refs_mem  [TOTAL_SLOTS];
  logic [19:0]       len_mem   [TOTAL_SLOTS];
  logic [31:0]       time_mem  [TOTAL_SLOTS];

  logic [19:0] blk_r [NUM_CLASSES];
  logic [19:0] maxreq_r;
  logic [TOP_W-1:0] top_r  [NUM_CLASSES];
  logic [TOP_W-1:0] peak_r [NUM_CLASSES];
  logic [31:0] fail_r;

  state_t state_r, state_nxt;
  in_item_t item_r;
  out_item_t res_r, res_nxt;
  logic [GIDX_W:0] cnt_r, cnt_nxt;
  logic [13:0] stale_r, stale_nxt;
  logic [1:0]  cls_r, cls_nxt;
  logic [SLOT_W-1:0] sl_r, sl_nxt;
  logic [31:0] fail_nxt;

  // memory port controls
  logic [GIDX_W-1:0] raddr, waddr, saddr_r, saddr;
  logic              rd_en, wr_refs, wr_len, wr_time, wr_stack, rd_stack;
  logic [15:0]       wd_refs;
  logic [19:0]       wd_len;
  logic [31:0]       wd_time;
  logic [SLOT_W-1:0] wd_stack;
  logic [15:0]       rd_refs;
  logic [19:0]       rd_len;
  logic [31:0]       rd_time;
  logic [SLOT_W-1:0] rd_stk;
  logic              top_dec, top_inc, peak_up;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r[0] <= 20'd1024;
      blk_r[1] <= 20'd8192;
      blk_r[2] <= 20'd65536;
      maxreq_r <= 20'd65536;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_SMALL:  blk_r[0] <= cfg_ch.data.data;
        REG_MEDIUM: blk_r[1] <= cfg_ch.data.data;
        REG_LARGE:  blk_r[2] <= cfg_ch.data.data;
        REG_MAXREQ: maxreq_r <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_refs <= refs_mem[raddr];
      rd_len  <= len_mem[raddr];
      rd_time <= time_mem[raddr];
    end
    if (wr_refs)  refs_mem[waddr] <= wd_refs;
    if (wr_len)   len_mem[waddr]  <= wd_len;
    if (wr_time)  time_mem[waddr] <= wd_time;
  end

  always_ff @(posedge clk) begin
    if (rd_stack) rd_stk <= stack_mem[saddr];
    if (wr_stack) stack_mem[saddr] <= wd_stack;
  end

  // shared multiplier: slot times block size, fed with the slot and class
  // about to be held so alloc multiplies the popped index
  logic [31:0] mul_r;
  logic [19:0] mul_blk;
  always_comb begin
    case (cls_nxt)
      2'd1:    mul_blk = blk_r[1];
      2'd2:    mul_blk = blk_r[2];
      default: mul_blk = blk_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= 32'(sl_nxt) * 32'(mul_blk);
  end

  logic all_free;
  always_comb begin
    all_free = 1'b1;
    for (int c = 0; c < NUM_CLASSES; c++)
      if (top_r[c] != TOP_W'(SLOTS_PER_CLASS)) all_free = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      fail_r  <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        top_r[c]  <= TOP_W'(SLOTS_PER_CLASS);
        peak_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fail_r  <= fail_nxt;
      if (top_dec) top_r[cls_r] <= top_r[cls_r] - 1'b1;
      if (top_inc) top_r[cls_r] <= top_r[cls_r] + 1'b1;
      if (peak_up) peak_r[cls_r] <= TOP_W'(SLOTS_PER_CLASS) - top_r[cls_r] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
    res_r   <= res_nxt;
    stale_r <= stale_nxt;
    cls_r   <= cls_nxt;
    sl_r    <= sl_nxt;
    saddr_r <= saddr;
  end

  logic [SLOT_W-1:0] init_slot;
  logic [1:0]        fit_cls;
  logic              fit_ok;
  logic              hnd_ok;

  always_comb begin
    init_slot = cnt_r[SLOT_W-1:0];
    if (item_r.length <= blk_r[0]) begin fit_cls = 2'd0; fit_ok = 1'b1; end
    else if (item_r.length <= blk_r[1]) begin fit_cls = 2'd1; fit_ok = 1'b1; end
    else if (item_r.length <= blk_r[2]) begin fit_cls = 2'd2; fit_ok = 1'b1; end
    else begin fit_cls = 2'd0; fit_ok = 1'b0; end
    hnd_ok = (item_r.class_num != 2'd3) && (item_r.slot_index < 12'(SLOTS_PER_CLASS));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    stale_nxt = stale_r;
    cls_nxt   = cls_r;
    sl_nxt    = sl_r;
    fail_nxt  = fail_r;
    raddr = '0; waddr = '0; saddr = saddr_r;
    rd_en = 1'b0; wr_refs = 1'b0; wr_len = 1'b0; wr_time = 1'b0;
    wr_stack = 1'b0; rd_stack = 1'b0;
    wd_refs = '0; wd_len = '0; wd_time = '0; wd_stack = '0;
    top_dec = 1'b0; top_inc = 1'b0; peak_up = 1'b0;
    case (state_r)
      S_INIT: begin
        // clear slot data and fill each stack with capacity-1 down to 0
        waddr = cnt_r[GIDX_W-1:0];
        saddr = cnt_r[GIDX_W-1:0];
        wr_refs = 1'b1; wr_len = 1'b1; wr_time = 1'b1; wr_stack = 1'b1;
        wd_stack = SLOT_W'(SLOTS_PER_CLASS - 1) - init_slot;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (GIDX_W+1)'(TOTAL_SLOTS - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_READ;
      end
      S_READ: begin
        res_nxt = '0;
        stale_nxt = '0;
        cnt_nxt = '0;
        res_nxt.hnd_class = item_r.class_num;
        res_nxt.handle_slot  = item_r.slot_index;
        cls_nxt = item_r.class_num;
        sl_nxt  = item_r.slot_index[SLOT_W-1:0];
        state_nxt = S_OUT;
        case (item_r.action)
          ACT_ALLOC: begin
            res_nxt.hnd_class = '0;
            res_nxt.handle_slot  = '0;
            if (item_r.length == '0 || item_r.length > maxreq_r || !fit_ok) begin
              res_nxt.status = ST_BAD_LEN;
              if (fail_r != '1) fail_nxt = fail_r + 1'b1;
            end else begin
              cls_nxt = fit_cls;
              res_nxt.hnd_class = fit_cls;
              if (top_r[fit_cls] == '0) begin
                res_nxt.status = ST_EXHAUSTED;
                if (fail_r != '1) fail_nxt = fail_r + 1'b1;
              end else begin
                saddr = gidx(fit_cls, SLOT_W'(top_r[fit_cls] - 1'b1));
                rd_stack = 1'b1;
                state_nxt = S_ACT;
              end
            end
          end
          ACT_RETAIN, ACT_RELEASE, ACT_QUERY: begin
            if (!hnd_ok) res_nxt.status = ST_BAD_HND;
            else begin
              raddr = gidx(item_r.class_num, item_r.slot_index[SLOT_W-1:0]);
              rd_en = 1'b1;
              state_nxt = S_ACT;
            end
          end
          ACT_STATS: begin
            if (item_r.class_num == 2'd3) res_nxt.status = ST_BAD_HND;
          end
          ACT_SWEEP: begin
            res_nxt.hnd_class = '0;
            res_nxt.handle_slot  = '0;
            cls_nxt = 2'd3;
            state_nxt = S_SWEEP_RD;
          end
          default: begin
            res_nxt.status = ST_BAD_HND;
            res_nxt.hnd_class = '0;
            res_nxt.handle_slot  = '0;
            cls_nxt = 2'd3;
          end
        endcase
      end
      S_ACT: begin
        state_nxt = S_MUL;
        waddr = gidx(cls_r, sl_r);
        case (item_r.action)
          ACT_ALLOC: begin
            sl_nxt = rd_stk;
            waddr = gidx(cls_r, rd_stk);
            top_dec = 1'b1;
            if (TOP_W'(SLOTS_PER_CLASS) - top_r[cls_r] + 1'b1 > peak_r[cls_r]) peak_up = 1'b1;
            wr_refs = 1'b1; wr_len = 1'b1; wr_time = 1'b1;
            wd_refs = 16'd1; wd_len = item_r.length; wd_time = item_r.now_ms;
            res_nxt.handle_slot = 12'(rd_stk);
            res_nxt.blob_length = item_r.length;
            res_nxt.ref_count = 16'd1;
          end
          ACT_RETAIN: begin
            if (rd_refs == '0 || rd_refs == '1) begin
              res_nxt.status = ST_REF_ERR;
              state_nxt = S_OUT;
            end else begin
              wr_refs = 1'b1; wd_refs = rd_refs + 1'b1;
              res_nxt.ref_count = wd_refs;
              res_nxt.blob_length = rd_len;
            end
          end
          ACT_RELEASE: begin
            if (rd_refs == '0) begin
              res_nxt.status = ST_REF_ERR;
              state_nxt = S_OUT;
            end else begin
              wr_refs = 1'b1; wd_refs = rd_refs - 1'b1;
              res_nxt.ref_count = wd_refs;
              res_nxt.blob_length = rd_len;
              if (rd_refs == 16'd1) begin
                wr_len = 1'b1; wr_time = 1'b1;
                res_nxt.blob_length = '0;
                if (top_r[cls_r] < TOP_W'(SLOTS_PER_CLASS)) begin
                  saddr = gidx(cls_r, top_r[cls_r][SLOT_W-1:0]);
                  wr_stack = 1'b1;
                  wd_stack = sl_r;
                  top_inc = 1'b1;
                end
              end
            end
          end
          default: begin
            res_nxt.ref_count = rd_refs;
            res_nxt.blob_length = rd_len;
          end
        endcase
      end
      S_MUL: begin
        // mul_r now holds slot times block size
        res_nxt.byte_offset = mul_r;
        state_nxt = S_OUT;
      end
      S_SWEEP_RD: begin
        raddr = cnt_r[GIDX_W-1:0];
        rd_en = 1'b1;
        state_nxt = S_SWEEP_CHK;
      end
      S_SWEEP_CHK: begin
        waddr = cnt_r[GIDX_W-1:0];
        if (rd_refs != '0 && (item_r.now_ms - rd_time) > item_r.age_limit) begin
          stale_nxt = stale_r + 1'b1;
          wr_time = 1'b1;
          wd_time = item_r.now_ms;
        end
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_SWEEP_RD;
        if (cnt_r == (GIDX_W+1)'(TOTAL_SLOTS - 1)) begin
          state_nxt = S_OUT;
          res_nxt.stale_count = stale_nxt;
        end
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // usage and global fields, tracked live so they show state after the op
    if (state_r != S_OUT && state_r != S_IDLE && state_r != S_INIT) begin
      res_nxt.failure_count = fail_nxt;
      res_nxt.all_free = all_free;
      if (cls_nxt != 2'd3 && !(state_r == S_READ && item_r.action == ACT_ALLOC
          && res_nxt.status == ST_BAD_LEN)) begin
        res_nxt.in_use = 13'(TOP_W'(SLOTS_PER_CLASS) - top_r[cls_nxt]);
        res_nxt.peak_used = 13'(peak_r[cls_nxt]);
      end else begin
        res_nxt.in_use = '0;
        res_nxt.peak_used = '0;
      end
    end
  end

  // high water never trails current use
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_chk
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_IDLE) |-> (TOP_W'(SLOTS_PER_CLASS) - top_r[c] <= peak_r[c]))
      else $error("peak below use");
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
      top_r[c] <= TOP_W'(SLOTS_PER_CLASS)) else $error("free top overflow");
  end
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("ready while busy");
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r >= $past(fail_r) || !$past(rst_n)) else $error("failure count fell");

endmodule

// ===== verif/tb_refcounted_size_class_block_pool.sv =====
// Testbench: random and directed traffic through the block pool, checked against a predictor.
`timescale 1ns / 1ps
module tb_refcounted_size_class_block_pool;
  import rcsbp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rcsbp_in_if  in_ch (clk);
  rcsbp_out_if out_ch (clk);
  rcsbp_cfg_if cfg_ch (clk);

  refcounted_size_class_block_pool dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  logic [19:0] blk_bytes [3];
  logic [19:0] max_req;
  logic [7:0]  free_idx [3][SLOTS_PER_CLASS];
  int          free_cnt [3];
  int          peak [3];
  int          refs [3][SLOTS_PER_CLASS];
  logic [19:0] lens [3][SLOTS_PER_CLASS];
  logic [31:0] stamps [3][SLOTS_PER_CLASS];
  logic [31:0] fails;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int  errors = 0;
  int  results_seen = 0;
  longint cycles = 0;
  bit  hold_sender = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_phase = 0;

  // live handles for well-formed traffic
  int held_cls[$];
  int held_slot[$];

  task automatic pool_reset();
    blk_bytes[0] = 20'd1024; blk_bytes[1] = 20'd8192; blk_bytes[2] = 20'd65536;
    max_req = 20'd65536;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
        free_idx[c][i] = 8'(SLOTS_PER_CLASS - 1 - i);
        refs[c][i] = 0; lens[c][i] = '0; stamps[c][i] = '0;
      end
      free_cnt[c] = SLOTS_PER_CLASS;
      peak[c] = 0;
    end
    fails = '0;
  endtask

  function automatic void note_fail();
    if (fails != 32'hFFFF_FFFF) fails++;
  endfunction

  function automatic out_item_t pool_predict(in_item_t it);
    out_item_t r;
    bit rep;
    int c, s;
    r = '0; rep = 0;
    c = it.class_num; s = it.slot_index;
    case (it.action)
      ACT_ALLOC: begin
        if (it.length == 0 || it.length > max_req) begin
          r.status = ST_BAD_LEN; note_fail();
        end else begin
          c = 0;
          while (c < 3 && it.length > blk_bytes[c]) c++;
          if (c >= 3) begin
            r.status = ST_BAD_LEN; note_fail();
          end else if (free_cnt[c] == 0) begin
            r.status = ST_EXHAUSTED; r.hnd_class = 2'(c); rep = 1; note_fail();
          end else begin
            free_cnt[c]--;
            s = free_idx[c][free_cnt[c]];
            if (SLOTS_PER_CLASS - free_cnt[c] > peak[c]) peak[c] = SLOTS_PER_CLASS - free_cnt[c];
            refs[c][s] = 1; lens[c][s] = it.length; stamps[c][s] = it.now_ms;
            r.hnd_class = 2'(c); r.handle_slot = 12'(s);
            r.byte_offset = 32'(s) * 32'(blk_bytes[c]);
            r.blob_length = it.length; r.ref_count = 16'd1; rep = 1;
          end
        end
      end
      ACT_RETAIN, ACT_RELEASE, ACT_QUERY: begin
        r.hnd_class = it.class_num; r.handle_slot = it.slot_index;
        if (c >= 3) r.status = ST_BAD_HND;
        else begin
          rep = 1;
          if (s >= SLOTS_PER_CLASS) r.status = ST_BAD_HND;
          else begin
            if (it.action == ACT_RETAIN) begin
              if (refs[c][s] == 0 || refs[c][s] >= 65535) r.status = ST_REF_ERR;
              else refs[c][s]++;
            end else if (it.action == ACT_RELEASE) begin
              if (refs[c][s] == 0) r.status = ST_REF_ERR;
              else begin
                refs[c][s]--;
                if (refs[c][s] == 0) begin
                  lens[c][s] = '0; stamps[c][s] = '0;
                  if (free_cnt[c] < SLOTS_PER_CLASS) begin
                    free_idx[c][free_cnt[c]] = 8'(s);
                    free_cnt[c]++;
                  end
                end
              end
            end
            if (r.status == ST_OK) begin
              r.byte_offset = 32'(s) * 32'(blk_bytes[c]);
              r.blob_length = lens[c][s]; r.ref_count = 16'(refs[c][s]);
            end
          end
        end
      end
      ACT_STATS: begin
        r.hnd_class = it.class_num; r.handle_slot = it.slot_index;
        if (c >= 3) r.status = ST_BAD_HND; else rep = 1;
      end
      ACT_SWEEP: begin
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < SLOTS_PER_CLASS; i++)
            if (refs[k][i] != 0 && (it.now_ms - stamps[k][i]) > it.age_limit) begin
              r.stale_count++;
              stamps[k][i] = it.now_ms;
            end
      end
      default: r.status = ST_BAD_HND;
    endcase
    if (rep) begin
      r.in_use = 13'(SLOTS_PER_CLASS - free_cnt[r.hnd_class]);
      r.peak_used = 13'(peak[r.hnd_class]);
    end
    r.failure_count = fails;
    r.all_free = (free_cnt[0] == SLOTS_PER_CLASS && free_cnt[1] == SLOTS_PER_CLASS
                  && free_cnt[2] == SLOTS_PER_CLASS);
    return r;
  endfunction

  // driver: bursts and gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(pool_predict(in_ch.data));
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        in_ch.data <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor with receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_item_t exp_r;
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, out_ch.data);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_ch.data) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_ch.data);
          end
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 24) out_ch.ready <= 1'b1;
      else if (stall_phase < 40) out_ch.ready <= ($urandom_range(0, 2) != 0);
      else out_ch.ready <= ((stall_phase % 5) != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3_000_000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
    cfg_ch.data <= '{index: idx, data: val};
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SMALL:  blk_bytes[0] = val;
      REG_MEDIUM: blk_bytes[1] = val;
      REG_LARGE:  blk_bytes[2] = val;
      default:    max_req = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (1700) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [2:0] a, logic [19:0] l, logic [1:0] c,
                                  logic [11:0] s, logic [31:0] n, logic [31:0] g);
    in_item_t it;
    it.action = a; it.length = l; it.class_num = c; it.slot_index = s;
    it.now_ms = n; it.age_limit = g;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int p;
    logic [1:0] c;
    logic [11:0] s;
    p = $urandom_range(0, 99);
    c = 2'($urandom_range(0, 2));
    s = 12'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      c = 2'($urandom); s = 12'($urandom);
    end
    if (p < 35) return mk(ACT_ALLOC, ($urandom_range(0, 9) == 0) ? 20'($urandom)
                          : 20'($urandom_range(0, 70000)), c, s, $urandom, $urandom);
    if (p < 50) return mk(ACT_RETAIN, 20'($urandom), c, s, $urandom, $urandom);
    if (p < 75) return mk(ACT_RELEASE, 20'($urandom), c, s, $urandom, $urandom);
    if (p < 85) return mk(ACT_QUERY, 20'($urandom), c, s, $urandom, $urandom);
    if (p < 93) return mk(ACT_STATS, 20'($urandom), 2'($urandom), 12'($urandom),
                          $urandom, $urandom);
    if (p < 97) return mk(ACT_SWEEP, 20'($urandom), c, s, $urandom,
                          ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1000))));
    return mk(3'($urandom_range(6, 7)), 20'($urandom), c, s, $urandom, $urandom);
  endfunction

  initial begin
    int n_sweeps;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    pool_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the fields and the bad length, bad handle and refcount error paths
    pending_items.push_back(mk(ACT_ALLOC, 20'd0, 0, 0, 32'd5, 0));
    pending_items.push_back(mk(ACT_ALLOC, 20'hFFFFF, 0, 0, 32'd5, 0));
    pending_items.push_back(mk(ACT_ALLOC, 20'd1, 0, 0, 32'hFFFF_FFFF, 0));
    pending_items.push_back(mk(ACT_ALLOC, 20'd1025, 0, 0, 32'd100, 0));
    pending_items.push_back(mk(ACT_ALLOC, 20'd65536, 0, 0, 32'd0, 0));
    pending_items.push_back(mk(ACT_RETAIN, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_RETAIN, 0, 0, 12'd255, 0, 0));
    pending_items.push_back(mk(ACT_RETAIN, 0, 2'd3, 0, 0, 0));
    pending_items.push_back(mk(ACT_RELEASE, 0, 1, 12'hFFF, 0, 0));
    pending_items.push_back(mk(ACT_QUERY, 0, 1, 0, 0, 0));
    pending_items.push_back(mk(ACT_QUERY, 0, 2'd3, 12'hFFF, 0, 0));
    pending_items.push_back(mk(ACT_STATS, 0, 2'd3, 0, 0, 0));
    pending_items.push_back(mk(ACT_STATS, 0, 2, 0, 0, 0));
    pending_items.push_back(mk(ACT_SWEEP, 0, 0, 0, 32'd50, 32'd10));
    pending_items.push_back(mk(ACT_SWEEP, 0, 0, 0, 32'd0, 32'hFFFF_FFFF));
    pending_items.push_back(mk(3'd6, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(3'd7, 20'hFFFFF, 2'd3, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(mk(ACT_RELEASE, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_RELEASE, 0, 0, 0, 0, 0));
    drain();

    // exhaust class two, then free it again
    for (int i = 0; i < SLOTS_PER_CLASS + 2; i++)
      pending_items.push_back(mk(ACT_ALLOC, 20'd60000, 0, 0, 32'(i), 0));
    // wait until every result is in
    drain();
    hold_sender = 1'b0;
    for (int i = 0; i < SLOTS_PER_CLASS; i++)
      pending_items.push_back(mk(ACT_RELEASE, 0, 2, 12'(i), 0, 0));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          cfg_write(REG_SMALL, 20'd1); cfg_write(REG_MEDIUM, 20'hFFFFF);
          cfg_write(REG_LARGE, 20'd0); cfg_write(REG_MAXREQ, 20'hFFFFF);
        end
        2: begin
          cfg_write(REG_SMALL, 20'd64); cfg_write(REG_MEDIUM, 20'd512);
          cfg_write(REG_LARGE, 20'hFFFFF); cfg_write(REG_MAXREQ, 20'd1);
        end
        3: begin
          cfg_write(REG_SMALL, 20'($urandom_range(1, 4000)));
          cfg_write(REG_MEDIUM, 20'($urandom_range(4000, 40000)));
          cfg_write(REG_LARGE, 20'($urandom_range(40000, 1048575)));
          cfg_write(REG_MAXREQ, 20'($urandom_range(30000, 70000)));
        end
        default: ;
      endcase
      for (int i = 0; i < 150; i++) pending_items.push_back(rand_item());
      drain();
    end

    // a short run of retains on one slot
    pending_items.push_back(mk(ACT_ALLOC, 20'd1, 0, 0, 0, 0));
    drain();
    for (int i = 0; i < 16; i++) pending_items.push_back(mk(ACT_RETAIN, 0, 0, 0, 0, 0));
    drain();

    $display("Covered directed edges, class exhaustion, %0d results over four register",
             results_seen);
    $display("settings, sweeps and repeated retains on one slot.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/rcsbp_pkg.sv
design/rcsbp_if.sv
design/refcounted_size_class_block_pool.sv
verif/tb_refcounted_size_class_block_pool.sv
